FILE: hw/rtl/ccrh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrh_pkg
// Shared types and constants for the CAN command responder with heartbeat.
// ----------------------------------------------------------------------------
package ccrh_pkg;

  // Item kinds on the input channel
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 2'd1;

  // Identifier bases
  localparam logic [10:0] CMD_ID_BASE  = 11'h300;
  localparam logic [10:0] RESP_ID_BASE = 11'h200;
  localparam logic [10:0] BEAT_ID_BASE = 11'h100;

  // Command codes
  localparam logic [7:0] CMD_PING     = 8'h01;
  localparam logic [7:0] CMD_READ     = 8'h02;
  localparam logic [7:0] CMD_SET_BEAT = 8'h03;

  // Status codes
  localparam logic [7:0] ST_OK      = 8'h00;
  localparam logic [7:0] ST_BAD_CMD = 8'hE0;
  localparam logic [7:0] ST_BAD_ARG = 8'hE1;

  localparam logic [7:0]  PING_MARK      = 8'hA5;
  localparam logic [7:0]  NODE_ID_RESET  = 8'd1;
  localparam logic [15:0] MIN_PER_RESET  = 16'd100;
  localparam logic [15:0] BEAT_DEFAULT   = 16'd1000;

  // Command classes decided by the front end
  localparam logic [1:0] CLS_PING = 2'd0;
  localparam logic [1:0] CLS_READ = 2'd1;
  localparam logic [1:0] CLS_SETP = 2'd2;
  localparam logic [1:0] CLS_BAD  = 2'd3;

  // Work queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic       is_tick;
    logic [1:0] cls;
    logic [7:0] cmd;
    logic [7:0] seq;
    logic [7:0] p_lo;
    logic [7:0] p_hi;
    logic [7:0] ctrl_error;
  } work_t;

endpackage

FILE: hw/rtl/ccrh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrh_front
// Filters received frames by identifier and classifies the command.
// ----------------------------------------------------------------------------
module ccrh_front import ccrh_pkg::*; (
  input  logic        op,
  input  logic [28:0] frame_id,
  input  logic        is_extended,
  input  logic [7:0]  rx_byte0,
  input  logic [7:0]  rx_byte1,
  input  logic [7:0]  rx_byte2,
  input  logic [7:0]  rx_byte3,
  input  logic [7:0]  ctrl_error,
  input  logic [7:0]  node_id,
  output logic        keep,
  output work_t       item
);

  logic [28:0] cmd_id;
  logic        match;

  assign cmd_id = 29'(CMD_ID_BASE) + 29'(node_id);
  assign match  = !is_extended && (frame_id == cmd_id);
  // ticks always go to the back end; frames only when addressed here
  assign keep   = (op == OP_TICK) || match;

  always_comb begin
    item.is_tick    = (op == OP_TICK);
    item.cmd        = rx_byte0;
    item.seq        = rx_byte1;
    item.p_lo       = rx_byte2;
    item.p_hi       = rx_byte3;
    item.ctrl_error = ctrl_error;
    case (rx_byte0)
      CMD_PING:     item.cls = CLS_PING;
      CMD_READ:     item.cls = CLS_READ;
      CMD_SET_BEAT: item.cls = CLS_SETP;
      default:      item.cls = CLS_BAD;
    endcase
  end

endmodule

FILE: hw/rtl/ccrh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrh_queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module ccrh_queue import ccrh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output work_t head
);

  work_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/ccrh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrh_back
// Executes queued items: counters, heartbeat timer and the transmit register.
// ----------------------------------------------------------------------------
module ccrh_back import ccrh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  node_id,
  input  logic [15:0] min_period,
  input  logic        head_valid,
  input  work_t       head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] tx_id,
  output logic [7:0]  tx_byte0,
  output logic [7:0]  tx_byte1,
  output logic [7:0]  tx_byte2,
  output logic [7:0]  tx_byte3,
  output logic [7:0]  tx_byte4,
  output logic [7:0]  tx_byte5,
  output logic [7:0]  tx_byte6,
  output logic [7:0]  tx_byte7
);

  logic [15:0] heartbeat_count;
  logic [15:0] sent_count;
  logic [15:0] received_count;
  logic [7:0]  last_command;
  logic [7:0]  last_result;
  logic [15:0] beat_period;
  logic [15:0] elapsed_ms;

  logic [15:0] elapsed_inc;
  logic        beat_due;
  logic [15:0] rx_count_next;
  logic [15:0] period;
  logic        period_low;
  logic [7:0]  status;
  logic [7:0]  d0, d1, d2, d3;
  logic        emit;

  assign pop = head_valid && (!out_valid || out_ready);

  assign elapsed_inc   = (elapsed_ms == 16'hFFFF) ? elapsed_ms : elapsed_ms + 16'd1;
  assign beat_due      = (elapsed_inc >= beat_period);
  assign rx_count_next = received_count + 16'd1;
  assign period        = {head.p_hi, head.p_lo};
  assign period_low    = (period < min_period);
  assign emit          = pop && (!head.is_tick || beat_due);

  always_comb begin
    status = ST_OK;
    d0 = 8'h00;
    d1 = 8'h00;
    d2 = 8'h00;
    d3 = 8'h00;
    case (head.cls)
      CLS_PING: begin
        d0 = PING_MARK;
        d1 = node_id;
      end
      CLS_READ: begin
        d0 = heartbeat_count[7:0];
        d1 = heartbeat_count[15:8];
        d2 = sent_count[7:0];
        d3 = rx_count_next[7:0];
      end
      CLS_SETP: begin
        if (period_low) begin
          status = ST_BAD_ARG;
        end else begin
          d0 = head.p_lo;
          d1 = head.p_hi;
        end
      end
      default: status = ST_BAD_CMD;
    endcase
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_count <= '0;
      sent_count      <= '0;
      received_count  <= '0;
      last_command    <= '0;
      last_result     <= '0;
      beat_period     <= BEAT_DEFAULT;
      elapsed_ms      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (emit) begin
        out_valid  <= 1'b1;
        sent_count <= sent_count + 16'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.is_tick) begin
          if (beat_due) begin
            elapsed_ms      <= '0;
            heartbeat_count <= heartbeat_count + 16'd1;
          end else begin
            elapsed_ms <= elapsed_inc;
          end
        end else begin
          received_count <= rx_count_next;
          last_command   <= head.cmd;
          last_result    <= status;
          if (head.cls == CLS_SETP && !period_low) begin
            beat_period <= period;
          end
        end
      end
    end
  end

  // Transmit payload
  always_ff @(posedge clk) begin
    if (emit) begin
      if (head.is_tick) begin
        tx_id    <= BEAT_ID_BASE + 11'(node_id);
        tx_byte0 <= node_id;
        tx_byte1 <= heartbeat_count[7:0];
        tx_byte2 <= heartbeat_count[15:8];
        tx_byte3 <= last_command;
        tx_byte4 <= last_result;
        tx_byte5 <= sent_count[7:0];
        tx_byte6 <= received_count[7:0];
        tx_byte7 <= head.ctrl_error;
      end else begin
        tx_id    <= RESP_ID_BASE + 11'(node_id);
        tx_byte0 <= head.cmd;
        tx_byte1 <= head.seq;
        tx_byte2 <= status;
        tx_byte3 <= node_id;
        tx_byte4 <= d0;
        tx_byte5 <= d1;
        tx_byte6 <= d2;
        tx_byte7 <= d3;
      end
    end
  end

endmodule

FILE: hw/rtl/can_command_responder_heartbeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_command_responder_heartbeat
// Node side of a CAN command link: command responses and periodic heartbeat.
// A response or heartbeat reaches out_valid through the queue write and then
// the result register.
// Throughput: one input item per cycle while the queue has room; the 4-entry
//   queue and the result register let input and output stall independently.
// Reset (rst, synchronous): counters cleared, period 1000 ms, node id 1,
//   minimum period 100 ms, queue empty, no result pending.
// ----------------------------------------------------------------------------
module can_command_responder_heartbeat import ccrh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // item input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [28:0]           frame_id,
  input  logic                  is_extended,
  input  logic [7:0]            rx_byte0,
  input  logic [7:0]            rx_byte1,
  input  logic [7:0]            rx_byte2,
  input  logic [7:0]            rx_byte3,
  input  logic [7:0]            ctrl_error,
  // frame output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [10:0]           tx_id,
  output logic [7:0]            tx_byte0,
  output logic [7:0]            tx_byte1,
  output logic [7:0]            tx_byte2,
  output logic [7:0]            tx_byte3,
  output logic [7:0]            tx_byte4,
  output logic [7:0]            tx_byte5,
  output logic [7:0]            tx_byte6,
  output logic [7:0]            tx_byte7,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers. Writes are always taken; an index beyond the
  // register list is dropped.
  logic [7:0]  node_id;
  logic [15:0] min_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id    <= NODE_ID_RESET;
      min_period <= MIN_PER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NODE_ID:    node_id    <= cfg_data[7:0];
        REG_MIN_PERIOD: min_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: address filter and command decode. Frames for other nodes
  // and extended frames are consumed here and never reach the queue.
  logic  keep;
  work_t front_item;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  work_t q_head;

  ccrh_front u_front (
    .op          (op),
    .frame_id    (frame_id),
    .is_extended (is_extended),
    .rx_byte0    (rx_byte0),
    .rx_byte1    (rx_byte1),
    .rx_byte2    (rx_byte2),
    .rx_byte3    (rx_byte3),
    .ctrl_error  (ctrl_error),
    .node_id     (node_id),
    .keep        (keep),
    .item        (front_item)
  );

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

  ccrh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Back end: owns all counters and the heartbeat timer, so state updates
  // happen strictly in arrival order; it pops one item per cycle whenever
  // the result register is free or being drained.
  ccrh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .node_id    (node_id),
    .min_period (min_period),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_id      (tx_id),
    .tx_byte0   (tx_byte0),
    .tx_byte1   (tx_byte1),
    .tx_byte2   (tx_byte2),
    .tx_byte3   (tx_byte3),
    .tx_byte4   (tx_byte4),
    .tx_byte5   (tx_byte5),
    .tx_byte6   (tx_byte6),
    .tx_byte7   (tx_byte7)
  );

endmodule

FILE: tb/ccrh_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrh_frame_checker
// Watches the item, register and frame channels of the command responder.
// Predicts each transmitted frame from its own copy of the node state and
// compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module ccrh_frame_checker import ccrh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  op,
  input  logic [28:0]           frame_id,
  input  logic                  is_extended,
  input  logic [7:0]            rx_byte0,
  input  logic [7:0]            rx_byte1,
  input  logic [7:0]            rx_byte2,
  input  logic [7:0]            rx_byte3,
  input  logic [7:0]            ctrl_error,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [10:0]           tx_id,
  input  logic [7:0]            tx_byte0,
  input  logic [7:0]            tx_byte1,
  input  logic [7:0]            tx_byte2,
  input  logic [7:0]            tx_byte3,
  input  logic [7:0]            tx_byte4,
  input  logic [7:0]            tx_byte5,
  input  logic [7:0]            tx_byte6,
  input  logic [7:0]            tx_byte7,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    frames_pending,
  output int                    resp_checked,
  output int                    beats_checked
);

  typedef struct packed {
    logic            is_beat;
    logic [10:0]     id;
    logic [7:0][7:0] data;   // data[0] is tx_byte0
  } tx_frame_t;

  tx_frame_t tx_frames_due[$];

  // shadow configuration and node state
  logic [7:0]  node_q;
  logic [15:0] minp_q;
  logic [15:0] beats, sent, rcvd, period, elapsed;
  logic [7:0]  prev_cmd, last_st;

  task automatic predict_tx_frame(input logic kind, input logic [28:0] fid,
                                  input logic ext, input logic [7:0] cmd,
                                  input logic [7:0] seq, input logic [7:0] p_lo,
                                  input logic [7:0] p_hi, input logic [7:0] cerr);
    tx_frame_t       f;
    logic [7:0]      st;
    logic [3:0][7:0] d;
    logic [15:0]     req;
    f  = '0;
    st = ST_OK;
    d  = '0;
    if (kind == OP_FRAME) begin
      if (ext || fid != 29'(CMD_ID_BASE) + 29'(node_q)) return;
      prev_cmd = cmd;
      rcvd     = rcvd + 16'd1;
      case (cmd)
        CMD_PING: begin
          d[0] = PING_MARK;
          d[1] = node_q;
        end
        CMD_READ: begin
          d = {rcvd[7:0], sent[7:0], beats[15:8], beats[7:0]};
        end
        CMD_SET_BEAT: begin
          req = {p_hi, p_lo};
          if (req < minp_q) begin
            st = ST_BAD_ARG;
          end else begin
            period = req;
            d[0]   = p_lo;
            d[1]   = p_hi;
          end
        end
        default: st = ST_BAD_CMD;
      endcase
      last_st = st;
      f.id    = RESP_ID_BASE + 11'(node_q);
      f.data  = {d[3], d[2], d[1], d[0], node_q, st, seq, cmd};
    end else begin
      if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
      if (elapsed < period) return;
      elapsed   = '0;
      f.is_beat = 1'b1;
      f.id      = BEAT_ID_BASE + 11'(node_q);
      f.data    = {cerr, rcvd[7:0], sent[7:0], last_st, prev_cmd,
                   beats[15:8], beats[7:0], node_q};
      beats     = beats + 16'd1;
    end
    sent = sent + 16'd1;
    tx_frames_due.push_back(f);
  endtask

  task automatic check_tx_frame();
    tx_frame_t       want;
    logic [7:0][7:0] got;
    got = {tx_byte7, tx_byte6, tx_byte5, tx_byte4,
           tx_byte3, tx_byte2, tx_byte1, tx_byte0};
    if (tx_frames_due.size() == 0) begin
      $display("%0t ns: frame with nothing expected, tx_id=%03h data=%016h",
               $time, tx_id, got);
      errors++;
      return;
    end
    want = tx_frames_due.pop_front();
    if (tx_id !== want.id) begin
      $display("%0t ns: tx_id expected %03h got %03h", $time, want.id, tx_id);
      errors++;
    end
    for (int k = 0; k < 8; k++) begin
      if (got[k] !== want.data[k]) begin
        $display("%0t ns: tx_byte%0d expected %02h got %02h",
                 $time, k, want.data[k], got[k]);
        errors++;
      end
    end
    if (want.is_beat) beats_checked++;
    else resp_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      node_q        = NODE_ID_RESET;
      minp_q        = MIN_PER_RESET;
      beats         = '0;
      sent          = '0;
      rcvd          = '0;
      prev_cmd      = '0;
      last_st       = '0;
      period        = BEAT_DEFAULT;
      elapsed       = '0;
      errors        = 0;
      resp_checked  = 0;
      beats_checked = 0;
      tx_frames_due.delete();
    end else begin
      if (out_valid && out_ready) check_tx_frame();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NODE_ID:    node_q = cfg_data[7:0];
          REG_MIN_PERIOD: minp_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_tx_frame(op, frame_id, is_extended, rx_byte0, rx_byte1,
                         rx_byte2, rx_byte3, ctrl_error);
    end
    frames_pending <= tx_frames_due.size();
  end

endmodule

FILE: tb/can_command_responder_heartbeat_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_command_responder_heartbeat_tb
// Stimulus and verdict for the CAN command responder with heartbeat.
// Directed frames and ticks hit every command, status and filter case, then
// six register settings each run a random mix of addressed frames, foreign
// frames and ticks, with random idling on both channels and one long stall
// of the frame receiver. A separate checker predicts and compares frames.
// ----------------------------------------------------------------------------
module can_command_responder_heartbeat_tb;
  import ccrh_pkg::*;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int IDLE_LIMIT     = 4000;  // cycles with no transfer anywhere
  localparam int RX_HOLD_CYCLES = 120;   // long receiver hold-off
  localparam int PHASE_ITEMS    = 70;
  localparam int SETTLE_CYCLES  = 8;     // covers the queue write and result register plus margin

  typedef struct packed {
    logic        op;
    logic [28:0] fid;
    logic        ext;
    logic [7:0]  b0, b1, b2, b3;
    logic [7:0]  cerr;
  } rx_item_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid, in_ready;
  logic                  op;
  logic [28:0]           frame_id;
  logic                  is_extended;
  logic [7:0]            rx_byte0, rx_byte1, rx_byte2, rx_byte3;
  logic [7:0]            ctrl_error;
  logic                  out_valid, out_ready;
  logic [10:0]           tx_id;
  logic [7:0]            tx_byte0, tx_byte1, tx_byte2, tx_byte3;
  logic [7:0]            tx_byte4, tx_byte5, tx_byte6, tx_byte7;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int chk_errors, frames_pending, resp_checked, beats_checked;

  // stimulus bookkeeping (what was written, so addressed frames can be built)
  logic [7:0]  cur_node;
  logic [15:0] cur_minp;
  bit          no_idle;    // both sides run without gaps while set
  bit          hold_req;   // stimulus asks the receiver for a long hold-off
  int          items_sent;
  int          idle_cycles;

  can_command_responder_heartbeat u_top (
    .clk, .rst,
    .in_valid, .in_ready, .op, .frame_id, .is_extended,
    .rx_byte0, .rx_byte1, .rx_byte2, .rx_byte3, .ctrl_error,
    .out_valid, .out_ready, .tx_id,
    .tx_byte0, .tx_byte1, .tx_byte2, .tx_byte3,
    .tx_byte4, .tx_byte5, .tx_byte6, .tx_byte7,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ccrh_frame_checker u_chk (
    .clk, .rst,
    .in_valid, .in_ready, .op, .frame_id, .is_extended,
    .rx_byte0, .rx_byte1, .rx_byte2, .rx_byte3, .ctrl_error,
    .out_valid, .out_ready, .tx_id,
    .tx_byte0, .tx_byte1, .tx_byte2, .tx_byte3,
    .tx_byte4, .tx_byte5, .tx_byte6, .tx_byte7,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors(chk_errors), .frames_pending, .resp_checked, .beats_checked
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: watchdog, no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver side: random ready, plus one long hold-off on request. The
  // hold is counted here, in negedges, independent of the sender.
  initial begin : rx_side
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && hold_left == 0) begin
        hold_left = RX_HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 30) idle_left = idle_gap();
      end
      @(negedge clk);
    end
  end

  function automatic rx_item_t frame_item(logic [28:0] fid, logic ext, logic [7:0] cmd,
                                          logic [7:0] seq, logic [7:0] lo, logic [7:0] hi);
    rx_item_t it;
    it.op   = OP_FRAME;
    it.fid  = fid;
    it.ext  = ext;
    it.b0   = cmd;
    it.b1   = seq;
    it.b2   = lo;
    it.b3   = hi;
    it.cerr = 8'($urandom);
    return it;
  endfunction

  // Frame addressed to the node as currently configured.
  function automatic rx_item_t cmd_item(logic [7:0] cmd, logic [7:0] lo, logic [7:0] hi);
    return frame_item(29'(CMD_ID_BASE) + 29'(cur_node), 1'b0, cmd, 8'($urandom), lo, hi);
  endfunction

  function automatic rx_item_t tick_item(logic [7:0] cerr);
    rx_item_t it;
    it      = frame_item(29'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
    it.op   = OP_TICK;
    it.cerr = cerr;
    return it;
  endfunction

  // Period for command 3: at or near the minimum, below it, or anything.
  function automatic logic [15:0] pick_period();
    int unsigned p;
    case ($urandom_range(0, 3))
      0: begin
        p = cur_minp + $urandom_range(0, 6);
        if (p > 16'hFFFF) p = 16'hFFFF;
      end
      1: p = (cur_minp == 0) ? $urandom_range(0, 65535) : $urandom_range(0, cur_minp - 1);
      2: p = $urandom_range(0, 65535);
      default: p = cur_minp;
    endcase
    return 16'(p);
  endfunction

  function automatic rx_item_t random_item();
    int          r;
    logic [7:0]  cmd;
    logic [15:0] p;
    r = $urandom_range(0, 99);
    if (r < 40) return tick_item(8'($urandom));
    if (r < 78) begin
      // addressed frame: mostly known commands, with random content
      case ($urandom_range(0, 9))
        0, 1, 2: cmd = CMD_PING;
        3, 4:    cmd = CMD_READ;
        5, 6, 7: cmd = CMD_SET_BEAT;
        default: cmd = 8'($urandom);
      endcase
      p = (cmd == CMD_SET_BEAT) ? pick_period() : 16'($urandom);
      return cmd_item(cmd, p[7:0], p[15:8]);
    end
    if (r < 86)
      return frame_item(29'(CMD_ID_BASE) + 29'(cur_node), 1'b1, 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom));
    if (r < 93)
      return frame_item(29'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
    // near miss: one identifier bit off
    return frame_item((29'(CMD_ID_BASE) + 29'(cur_node)) ^ (29'd1 << $urandom_range(0, 28)),
                      1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // One input transfer. Valid only drops when a gap is taken, so a
  // back-to-back item keeps it high with a single assignment.
  task automatic send_item(input rx_item_t it);
    int g;
    g = no_idle ? 0 : idle_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    op          <= it.op;
    frame_id    <= it.fid;
    is_extended <= it.ext;
    rx_byte0    <= it.b0;
    rx_byte1    <= it.b1;
    rx_byte2    <= it.b2;
    rx_byte3    <= it.b3;
    ctrl_error  <= it.cerr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic set_period(input logic [15:0] p);
    send_item(cmd_item(CMD_SET_BEAT, p[7:0], p[15:8]));
  endtask

  // Drop input valid, drain every expected frame, then let the pipe empty
  // of items that make no frame.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (frames_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NODE_ID:    cur_node = data[7:0];
      REG_MIN_PERIOD: cur_minp = data;
      default: ;
    endcase
  endtask

  // New register setting (block idle), a spare-index write that must be
  // ignored, a period at the new minimum, then random traffic.
  task automatic run_phase(input logic [7:0] node, input logic [15:0] minp);
    settle();
    write_reg(REG_NODE_ID, {8'($urandom), node});
    write_reg(REG_MIN_PERIOD, minp);
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    set_period(minp);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      no_idle = (i % 50) < 10;   // stretch without gaps on both sides
      send_item(random_item());
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = OP_FRAME;
    frame_id    = '0;
    is_extended = 1'b0;
    rx_byte0    = '0;
    rx_byte1    = '0;
    rx_byte2    = '0;
    rx_byte3    = '0;
    ctrl_error  = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_NODE_ID;
    cfg_data    = '0;
    cur_node    = NODE_ID_RESET;
    cur_minp    = MIN_PER_RESET;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed: reset settings, node 1, min period 100, period 1000 ---
    send_item(frame_item(29'h301, 1'b0, CMD_PING, 8'h00, 8'hFF, 8'hFF));
    send_item(frame_item(29'h301, 1'b0, CMD_READ, 8'hFF, 8'h00, 8'h00));
    send_item(frame_item(29'h301, 1'b0, 8'h00, 8'h55, 8'hAA, 8'h55));      // unknown cmd
    send_item(frame_item(29'h301, 1'b0, 8'hFF, 8'hAA, 8'h55, 8'hAA));      // unknown cmd
    send_item(frame_item(29'h301, 1'b0, CMD_SET_BEAT, 8'h01, 8'd99, 8'd0)); // below minimum
    // frames not addressed here: extended, wrong id, identifier extremes; then an addressed read
    send_item(frame_item(29'h301, 1'b1, CMD_PING, 8'h02, 8'h00, 8'h00));
    send_item(frame_item(29'h300, 1'b0, CMD_PING, 8'h03, 8'h00, 8'h00));
    send_item(frame_item(29'h1FFFFFFF, 1'b0, CMD_PING, 8'h04, 8'h00, 8'h00));
    send_item(frame_item(29'h1FFFFFFF, 1'b1, CMD_PING, 8'h05, 8'h00, 8'h00));
    send_item(frame_item(29'h0, 1'b0, CMD_READ, 8'h06, 8'h00, 8'h00));
    send_item(frame_item(29'h301, 1'b0, CMD_READ, 8'h07, 8'h00, 8'h00));

    // default period 1000: these ticks stay short of the first heartbeat
    no_idle = 1'b1;
    for (int i = 0; i < 130; i++) send_item(tick_item(8'(i)));
    no_idle = 1'b0;

    send_item(frame_item(29'h301, 1'b0, CMD_SET_BEAT, 8'h08, 8'd100, 8'd0)); // exactly min
    send_item(frame_item(29'h301, 1'b0, CMD_SET_BEAT, 8'h09, 8'hFF, 8'hFF)); // 65535
    send_item(frame_item(29'h301, 1'b0, CMD_READ, 8'h0A, 8'h00, 8'h00));
    repeat (4) send_item(tick_item(8'h00));

    // --- node 0, minimum 0: period cut below elapsed, then zero period ---
    settle();
    write_reg(REG_NODE_ID, 16'h0000);
    write_reg(REG_MIN_PERIOD, 16'h0000);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h5A5A);
    set_period(16'd2);                       // elapsed already well past 2: next tick fires
    send_item(tick_item(8'h11));
    set_period(16'd0);                       // every tick is a heartbeat
    repeat (3) send_item(tick_item(8'(items_sent)));
    set_period(16'd3);

    // --- long receiver hold-off while the sender keeps offering pings ---
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (16) send_item(cmd_item(CMD_PING, 8'($urandom), 8'($urandom)));
    no_idle  = 1'b0;

    // --- random traffic over several register settings ---
    run_phase(NODE_ID_RESET, MIN_PER_RESET);
    run_phase(8'd0, 16'd0);
    run_phase(8'd255, 16'hFFFF);
    run_phase(8'($urandom), 16'($urandom_range(0, 10)));
    run_phase(8'($urandom), 16'd1);
    run_phase(8'h80, 16'd3);

    settle();
    $display("run covered %0d items: %0d responses and %0d heartbeats compared",
             items_sent, resp_checked, beats_checked);
    $display("register settings included node ids 0 and 255, minimum periods 0 and 65535");
    if (chk_errors == 0 && frames_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
